// ----- design/pareto_nondominated_rank_sort_top_assert.svh -----
// assertion macros shared by the rank sort design
`ifndef PARETO_NONDOMINATED_RANK_SORT_TOP_ASSERT_SVH
`define PARETO_NONDOMINATED_RANK_SORT_TOP_ASSERT_SVH

// same-cycle implication
`define PNRS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pnrs check failed");

// next-cycle implication
`define PNRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pnrs check failed");

`endif

// ----- design/pnrs_pkg.sv -----
// shared types and constants of the rank sort block
package pnrs_pkg;

   localparam int POPULATION_MAX_DEF = 64;
   localparam int OBJECTIVES_MAX_DEF = 4;
   localparam int OBJ_PORTS          = 4;
   localparam int OBJ_W              = 32;
   localparam int COUNT_W            = 3;
   localparam int INDEX_W            = 6;
   localparam int RANK_W             = 7;
   localparam logic [COUNT_W-1:0] OBJ_COUNT_RESET = 3'd2;

   typedef logic [OBJ_W-1:0] objective_type;
   typedef objective_type [OBJ_PORTS-1:0] objective_set_type;

   typedef struct packed {
      logic load_en;
      logic latch_en;
      logic mark_en;
      logic clear;
   } cell_ctrl_type;

endpackage

// ----- design/pnrs_cell.sv -----
// one population slot: stored objectives, dominated-by column and rank flags
module pnrs_cell #(
   parameter int POP     = pnrs_pkg::POPULATION_MAX_DEF,
   parameter int OBJ_MAX = pnrs_pkg::OBJECTIVES_MAX_DEF,
   parameter int IDX     = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pnrs_pkg::cell_ctrl_type           ctrl,
   input  pnrs_pkg::objective_set_type       objectives,
   input  logic [pnrs_pkg::COUNT_W-1:0]      active_count,
   input  logic [$clog2(POP)-1:0]            load_index,
   input  logic [$clog2(POP)-1:0]            mark_index,
   input  logic [POP-1:0]                    beats_new_vec,
   input  logic [POP-1:0]                    pending_vec,
   output logic                              pending,
   output logic                              beats_new,
   output logic                              front
);

   localparam int IW = $clog2(POP);

   pnrs_pkg::objective_type obj_ff [OBJ_MAX];
   logic [POP-1:0] col_ff;
   logic           valid_ff;
   logic           done_ff;
   logic           front_ff;
   logic           better_me;
   logic           better_new;
   logic           beaten_by_new;
   logic           load_here;

   always_comb begin
      better_me  = 1'b0;
      better_new = 1'b0;
      for (int k = 0; k < OBJ_MAX; k++) begin
         if (pnrs_pkg::COUNT_W'(k) < active_count) begin
            if (obj_ff[k] < objectives[k]) begin
               better_me = 1'b1;
            end else if (objectives[k] < obj_ff[k]) begin
               better_new = 1'b1;
            end
         end
      end
   end

   assign beats_new     = valid_ff & better_me & ~better_new;
   assign beaten_by_new = valid_ff & better_new & ~better_me;
   assign load_here     = ctrl.load_en && (load_index == IW'(IDX));
   assign pending       = valid_ff & ~done_ff;
   assign front         = front_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
         front_ff <= 1'b0;
      end else if (ctrl.clear) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
         front_ff <= 1'b0;
      end else begin
         if (load_here) begin
            valid_ff <= 1'b1;
            done_ff  <= 1'b0;
         end
         if (ctrl.latch_en) begin
            // free of every still-unranked dominator
            front_ff <= pending & ~|(col_ff & pending_vec);
         end
         if (ctrl.mark_en && (mark_index == IW'(IDX))) begin
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_here) begin
         col_ff <= beats_new_vec;
         for (int k = 0; k < OBJ_MAX; k++) begin
            obj_ff[k] <= objectives[k];
         end
      end else if (ctrl.load_en && beaten_by_new) begin
         col_ff[load_index] <= 1'b1;
      end
   end

endmodule

// ----- design/pareto_nondominated_rank_sort_top.sv -----
// pareto rank sort: load individuals into a row of cells, then peel fronts
//
// usage: one individual is taken at each edge with start high and busy low,
// one word per cycle while loading; every stored cell compares itself with
// the arriving word in parallel. csr_ objective_count may be written while
// idle (csr_ready is always high). the word flagged final_member starts the
// sort and raises busy. each front takes a latch state and then a scan in
// which the pointer walks every loaded member, and a finish state closes the
// sort. results leave on rsp_ for one cycle each under rsp_valid, front by
// front, ascending index, with rsp_last_result on the final one; the
// receiver cannot stall. a result is held back one find so the last can be
// marked, so the last word comes out with the return to idle. a population
// of zero gives no result. reset empties the population and sets
// objective_count to two.
module pareto_nondominated_rank_sort_top #(
   parameter int POPULATION_MAX = pnrs_pkg::POPULATION_MAX_DEF,
   parameter int OBJECTIVES_MAX = pnrs_pkg::OBJECTIVES_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [pnrs_pkg::OBJ_W-1:0]         req_objective_a,
   input  logic [pnrs_pkg::OBJ_W-1:0]         req_objective_b,
   input  logic [pnrs_pkg::OBJ_W-1:0]         req_objective_c,
   input  logic [pnrs_pkg::OBJ_W-1:0]         req_objective_d,
   input  logic                               req_final_member,
   output logic                               rsp_valid,
   output logic [pnrs_pkg::INDEX_W-1:0]       rsp_member_index,
   output logic [pnrs_pkg::RANK_W-1:0]        rsp_front_rank,
   output logic                               rsp_last_result,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pnrs_pkg::COUNT_W-1:0]       csr_objective_count
);

`include "pareto_nondominated_rank_sort_top_assert.svh"

   localparam int IW = $clog2(POPULATION_MAX);
   localparam int CW = $clog2(POPULATION_MAX + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_LATCH, ST_SCAN, ST_FINISH} state_type;

   state_type                      state_ff;
   logic [CW-1:0]                  loaded_ff;
   logic [CW-1:0]                  ranked_ff;
   logic [IW-1:0]                  ptr_ff;
   logic [pnrs_pkg::RANK_W-1:0]    rank_ff;
   logic                           found_ff;
   logic                           pend_valid_ff;
   logic [IW-1:0]                  pend_idx_ff;
   logic [pnrs_pkg::RANK_W-1:0]    pend_rank_ff;
   logic                           rsp_valid_ff;
   logic [pnrs_pkg::INDEX_W-1:0]   rsp_idx_ff;
   logic [pnrs_pkg::RANK_W-1:0]    rsp_rank_ff;
   logic                           rsp_last_ff;
   logic [pnrs_pkg::COUNT_W-1:0]   obj_count_ff;

   logic                           accept;
   logic                           hit;
   logic                           scan_end;
   logic [CW-1:0]                  loaded_in;
   logic [CW-1:0]                  ranked_in;
   logic [pnrs_pkg::COUNT_W-1:0]   active_count;
   pnrs_pkg::cell_ctrl_type        ctrl;
   pnrs_pkg::objective_set_type    objectives;
   logic [POPULATION_MAX-1:0]      pending_vec;
   logic [POPULATION_MAX-1:0]      beats_new_vec;
   logic [POPULATION_MAX-1:0]      front_vec;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_member_index = rsp_idx_ff;
   assign rsp_front_rank   = rsp_rank_ff;
   assign rsp_last_result  = rsp_last_ff;

   assign objectives[0] = req_objective_a;
   assign objectives[1] = req_objective_b;
   assign objectives[2] = req_objective_c;
   assign objectives[3] = req_objective_d;

   always_comb begin
      if (obj_count_ff == '0) begin
         active_count = pnrs_pkg::COUNT_W'(1);
      end else if (obj_count_ff > pnrs_pkg::COUNT_W'(OBJECTIVES_MAX)) begin
         active_count = pnrs_pkg::COUNT_W'(OBJECTIVES_MAX);
      end else begin
         active_count = obj_count_ff;
      end
   end

   always_comb begin
      ctrl.load_en  = accept && (loaded_ff < CW'(POPULATION_MAX));
      ctrl.latch_en = (state_ff == ST_LATCH);
      ctrl.mark_en  = (state_ff == ST_SCAN) && hit;
      ctrl.clear    = (state_ff == ST_FINISH);
   end

   assign hit       = front_vec[ptr_ff];
   assign scan_end  = (CW'(ptr_ff) + CW'(1)) == loaded_ff;
   assign loaded_in = ctrl.load_en ? loaded_ff + CW'(1) : loaded_ff;
   assign ranked_in = hit ? ranked_ff + CW'(1) : ranked_ff;

   for (genvar g = 0; g < POPULATION_MAX; g++) begin : g_cell
      pnrs_cell #(
         .POP     (POPULATION_MAX),
         .OBJ_MAX (OBJECTIVES_MAX),
         .IDX     (g)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .objectives    (objectives),
         .active_count  (active_count),
         .load_index    (loaded_ff[IW-1:0]),
         .mark_index    (ptr_ff),
         .beats_new_vec (beats_new_vec),
         .pending_vec   (pending_vec),
         .pending       (pending_vec[g]),
         .beats_new     (beats_new_vec[g]),
         .front         (front_vec[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obj_count_ff <= pnrs_pkg::OBJ_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         obj_count_ff <= csr_objective_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         loaded_ff     <= '0;
         ranked_ff     <= '0;
         ptr_ff        <= '0;
         rank_ff       <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  loaded_ff <= loaded_in;
                  if (req_final_member) begin
                     rank_ff       <= pnrs_pkg::RANK_W'(1);
                     ranked_ff     <= '0;
                     pend_valid_ff <= 1'b0;
                     state_ff      <= (loaded_in == '0) ? ST_FINISH : ST_LATCH;
                  end
               end
            end
            ST_LATCH: begin
               ptr_ff   <= '0;
               found_ff <= 1'b0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (hit) begin
                  // previous find goes out now, this one waits
                  rsp_valid_ff  <= pend_valid_ff;
                  rsp_idx_ff    <= pnrs_pkg::INDEX_W'(pend_idx_ff);
                  rsp_rank_ff   <= pend_rank_ff;
                  pend_valid_ff <= 1'b1;
                  pend_idx_ff   <= ptr_ff;
                  pend_rank_ff  <= rank_ff;
                  found_ff      <= 1'b1;
               end
               ranked_ff <= ranked_in;
               ptr_ff    <= ptr_ff + IW'(1);
               if (scan_end) begin
                  if ((found_ff || hit) && (ranked_in != loaded_ff)) begin
                     rank_ff  <= rank_ff + pnrs_pkg::RANK_W'(1);
                     state_ff <= ST_LATCH;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               rsp_valid_ff  <= pend_valid_ff;
               rsp_last_ff   <= pend_valid_ff;
               rsp_idx_ff    <= pnrs_pkg::INDEX_W'(pend_idx_ff);
               rsp_rank_ff   <= pend_rank_ff;
               pend_valid_ff <= 1'b0;
               loaded_ff     <= '0;
               ranked_ff     <= '0;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `PNRS_ASSERT_SAME(a_last_at_idle, clock, reset, rsp_valid && rsp_last_result, state_ff == ST_IDLE)
   `PNRS_ASSERT_SAME(a_ranked_bound, clock, reset, 1'b1, ranked_ff <= loaded_ff)
   `PNRS_ASSERT_NEXT(a_final_busy, clock, reset, start && !busy && req_final_member, busy)
   `PNRS_ASSERT_SAME(a_scan_ptr, clock, reset, state_ff == ST_SCAN, CW'(ptr_ff) < loaded_ff)

endmodule

// ----- verif/testbench.sv -----
// testbench for the pareto rank sort: queued driver, clocked monitor, built-in front predictor
`timescale 1ns / 1ps

module testbench;

   localparam int IDLE_LIMIT = 40000;

   typedef struct {
      logic [pnrs_pkg::OBJ_W-1:0] obj_a, obj_b, obj_c, obj_d;
      logic                       fin;
   } member_word_type;

   typedef struct {
      logic [pnrs_pkg::INDEX_W-1:0] idx;
      logic [pnrs_pkg::RANK_W-1:0]  rank;
      logic                         last;
   } ranked_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [pnrs_pkg::OBJ_W-1:0] req_objective_a = '0, req_objective_b = '0;
   logic [pnrs_pkg::OBJ_W-1:0] req_objective_c = '0, req_objective_d = '0;
   logic req_final_member = 1'b0;
   logic rsp_valid;
   logic [pnrs_pkg::INDEX_W-1:0] rsp_member_index;
   logic [pnrs_pkg::RANK_W-1:0] rsp_front_rank;
   logic rsp_last_result;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pnrs_pkg::COUNT_W-1:0] csr_objective_count = '0;

   pareto_nondominated_rank_sort_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_objective_a(req_objective_a), .req_objective_b(req_objective_b),
      .req_objective_c(req_objective_c), .req_objective_d(req_objective_d),
      .req_final_member(req_final_member),
      .rsp_valid(rsp_valid), .rsp_member_index(rsp_member_index),
      .rsp_front_rank(rsp_front_rank), .rsp_last_result(rsp_last_result),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_objective_count(csr_objective_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   member_word_type pending_members[$];
   ranked_word_type expected_ranks[$];
   int mismatches = 0;
   int idle_cycles = 0;
   logic took = 1'b0;

   // predictor state
   logic [pnrs_pkg::OBJ_W-1:0]
      obj_store[pnrs_pkg::POPULATION_MAX_DEF][pnrs_pkg::OBJECTIVES_MAX_DEF];
   int                           dom_count[pnrs_pkg::POPULATION_MAX_DEF];
   logic [63:0]                  dom_rows[pnrs_pkg::POPULATION_MAX_DEF];
   int                           pop_size = 0;
   logic [pnrs_pkg::COUNT_W-1:0] obj_count = pnrs_pkg::OBJ_COUNT_RESET;

   initial begin
      for (int i = 0; i < pnrs_pkg::POPULATION_MAX_DEF; i++) begin
         dom_count[i] = 0;
         dom_rows[i] = '0;
         for (int k = 0; k < pnrs_pkg::OBJECTIVES_MAX_DEF; k++) obj_store[i][k] = '0;
      end
   end

   // 1: a dominates b, -1: b dominates a
   function automatic int dominance(int a, int b, int n);
      bit a_better, b_better;
      a_better = 0;
      b_better = 0;
      for (int k = 0; k < n; k++) begin
         if (obj_store[a][k] < obj_store[b][k]) a_better = 1;
         else if (obj_store[b][k] < obj_store[a][k]) b_better = 1;
      end
      if (a_better && !b_better) return 1;
      if (b_better && !a_better) return -1;
      return 0;
   endfunction

   task automatic rank_member(member_word_type m);
      int n, rel, rank, produced, me;
      logic [63:0] done_set, all_set, front;
      ranked_word_type r;
      n = obj_count;
      if (n < 1) n = 1;
      if (n > pnrs_pkg::OBJECTIVES_MAX_DEF) n = pnrs_pkg::OBJECTIVES_MAX_DEF;
      if (pop_size < pnrs_pkg::POPULATION_MAX_DEF) begin
         me = pop_size;
         obj_store[me][0] = m.obj_a;
         obj_store[me][1] = m.obj_b;
         obj_store[me][2] = m.obj_c;
         obj_store[me][3] = m.obj_d;
         for (int i = 0; i < me; i++) begin
            rel = dominance(i, me, n);
            if (rel == 1) begin
               dom_rows[i][me] = 1'b1;
               dom_count[me]++;
            end else if (rel == -1) begin
               dom_rows[me][i] = 1'b1;
               dom_count[i]++;
            end
         end
         pop_size = me + 1;
      end
      if (!m.fin) return;
      all_set = (pop_size >= 64) ? '1 : ((64'd1 << pop_size) - 64'd1);
      done_set = '0;
      produced = 0;
      for (rank = 1; rank <= pnrs_pkg::POPULATION_MAX_DEF && done_set != all_set; rank++) begin
         front = '0;
         for (int i = 0; i < pop_size; i++)
            if (!done_set[i] && dom_count[i] == 0) front[i] = 1'b1;
         if (front == '0) break;
         for (int i = 0; i < pop_size; i++)
            if (front[i]) begin
               r.idx = i[pnrs_pkg::INDEX_W-1:0];
               r.rank = rank[pnrs_pkg::RANK_W-1:0];
               r.last = 1'b0;
               expected_ranks.insert(expected_ranks.size(), r);
               produced++;
            end
         for (int i = 0; i < pop_size; i++)
            if (front[i])
               for (int k = 0; k < pop_size; k++)
                  if (dom_rows[i][k] && dom_count[k] > 0) dom_count[k]--;
         done_set |= front;
      end
      if (produced > 0) expected_ranks[expected_ranks.size()-1].last = 1'b1;
      pop_size = 0;
      for (int i = 0; i < pnrs_pkg::POPULATION_MAX_DEF; i++) begin
         dom_count[i] = 0;
         dom_rows[i] = '0;
      end
   endtask

   // monitor: results, accepted words and register writes
   always @(posedge clock) begin
      member_word_type m;
      ranked_word_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_ranks.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result idx=%0d rank=%0d last=%0b",
                           rsp_member_index, rsp_front_rank, rsp_last_result);
            end else begin
               e = expected_ranks.pop_front();
               if (rsp_member_index !== e.idx || rsp_front_rank !== e.rank ||
                   rsp_last_result !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected idx=%0d rank=%0d last=%0b, got %0d %0d %0b",
                              e.idx, e.rank, e.last, rsp_member_index, rsp_front_rank,
                              rsp_last_result);
               end
            end
         end
         if (start && !busy) begin
            m.obj_a = req_objective_a;
            m.obj_b = req_objective_b;
            m.obj_c = req_objective_c;
            m.obj_d = req_objective_d;
            m.fin = req_final_member;
            rank_member(m);
         end
         // a write takes effect for words after this edge
         if (csr_valid && csr_ready) obj_count = csr_objective_count;
      end
      took <= !reset && start && !busy;
   end

   // driver: bursts of words with random gaps
   int burst_left = 4;
   int gap_left = 0;
   always @(negedge clock) begin
      member_word_type m;
      if (took) void'(pending_members.pop_front());
      if (reset) begin
         start <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
         start <= 1'b0;
      end else if (pending_members.size() > 0) begin
         m = pending_members[0];
         req_objective_a <= m.obj_a;
         req_objective_b <= m.obj_b;
         req_objective_c <= m.obj_c;
         req_objective_d <= m.obj_d;
         req_final_member <= m.fin;
         start <= 1'b1;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         end
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [pnrs_pkg::OBJ_W-1:0] pick_objective();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom;
         default: return $urandom_range(0, 5);
      endcase
   endfunction

   task automatic queue_member(logic [pnrs_pkg::OBJ_W-1:0] a, b, c, d, logic fin);
      member_word_type m;
      m.obj_a = a;
      m.obj_b = b;
      m.obj_c = c;
      m.obj_d = d;
      m.fin = fin;
      pending_members.insert(pending_members.size(), m);
   endtask

   task automatic queue_population(int size, bit closed);
      for (int i = 0; i < size; i++)
         queue_member(pick_objective(), pick_objective(), pick_objective(),
                      pick_objective(), closed && (i == size - 1));
   endtask

   task automatic drain();
      while (pending_members.size() > 0 || expected_ranks.size() > 0 || busy || start)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_count(logic [pnrs_pkg::COUNT_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_objective_count <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [pnrs_pkg::COUNT_W-1:0] counts[8] =
         '{3'd3, 3'd0, 3'd7, 3'd5, 3'd6, 3'd2, 3'd4, 3'd1};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, equal members, chain of dominance
      queue_member('0, '0, '0, '0, 1'b0);
      queue_member('1, '1, '1, '1, 1'b0);
      queue_member('0, '0, '0, '0, 1'b0);
      queue_member(32'd1, '0, '1, '0, 1'b0);
      queue_member('0, 32'd1, '0, '1, 1'b0);
      queue_member(32'd5, 32'd5, 32'd0, 32'd0, 1'b0);
      queue_member(32'd6, 32'd6, 32'd1, 32'd1, 1'b1);
      queue_member(32'd9, 32'd9, 32'd9, 32'd9, 1'b1);
      drain();
      // count changed while a population is half loaded
      write_count(3'd1);
      queue_member(32'd2, 32'd0, 32'd0, 32'd0, 1'b0);
      queue_member(32'd1, 32'd3, 32'd0, 32'd0, 1'b0);
      queue_member(32'd3, 32'd3, 32'd1, 32'd2, 1'b0);
      drain();
      write_count(3'd4);
      queue_member(32'd2, 32'd0, 32'd0, 32'd1, 1'b0);
      queue_member(32'd1, 32'd1, 32'd1, 32'd1, 1'b1);
      drain();

      foreach (counts[p]) begin
         write_count(counts[p]);
         if (p == 6) begin
            // overfull population: the extra words are dropped
            queue_population(66, 1'b1);
            drain();
         end
         for (int j = 0; j < 3; j++) queue_population($urandom_range(1, 9), 1'b1);
         queue_population($urandom_range(1, 4), 1'b0);
         drain();
      end
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_ranks.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/pnrs_pkg.sv
design/pnrs_cell.sv
design/pareto_nondominated_rank_sort_top.sv
verif/testbench.sv
